// ===== design/one_wire_bus_master_macros.svh =====
// Assertion macros for the one-wire bus master.
// Used by design/one_wire_bus_master.sv; expects i_clk and i_rst_n in scope.
`ifndef ONE_WIRE_BUS_MASTER_MACROS_SVH
`define ONE_WIRE_BUS_MASTER_MACROS_SVH
`ifndef SYNTHESIS
`define OWBM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define OWBM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define OWBM_ASSERT_IMP(label, ante, cons, msg)
`define OWBM_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== design/owbm_pkg.sv =====
// Shared types and codes for the one-wire bus master.
// Used by design/owbm_step.sv and design/one_wire_bus_master.sv.
package owbm_pkg;

    localparam int TICK_W    = 12;
    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_SEL_W = 3;

    // register indexes
    localparam int REG_RESET_LOW     = 0;
    localparam int REG_PRESENCE_WAIT = 1;
    localparam int REG_RESET_TAIL    = 2;
    localparam int REG_SLOT_LOW      = 3;
    localparam int REG_WRITE_HOLD    = 4;
    localparam int REG_READ_SAMPLE   = 5;
    localparam int REG_READ_TAIL     = 6;
    localparam int REG_RECOVERY      = 7;

    // actions
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_RESET = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;
    localparam logic [1:0] ACT_READ  = 2'd3;

    // phases
    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_RST_LOW  = 4'd1;
    localparam logic [3:0] PH_RST_WAIT = 4'd2;
    localparam logic [3:0] PH_RST_TAIL = 4'd3;
    localparam logic [3:0] PH_SLOT_LOW = 4'd4;
    localparam logic [3:0] PH_WR_HOLD  = 4'd5;
    localparam logic [3:0] PH_RD_WAIT  = 4'd6;
    localparam logic [3:0] PH_RD_TAIL  = 4'd7;
    localparam logic [3:0] PH_RECOVER  = 4'd8;

    localparam logic [2:0] LAST_BIT = 3'd7;

    typedef logic [0:NUM_REGS-1][TICK_W-1:0] t_cfg_regs;

    localparam t_cfg_regs CFG_DEFAULTS = '{
        12'd600, 12'd60, 12'd110, 12'd2, 12'd60, 12'd2, 12'd60, 12'd10
    };

    typedef struct packed {
        logic [3:0]        phase;
        logic [TICK_W-1:0] count;
        logic [2:0]        bit_idx;
        logic [7:0]        shift;
        logic              presence;
        logic [1:0]        op;
        logic [7:0]        read_result;
    } t_state;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] read_byte;
        logic       rejected;
    } t_result;

endpackage

// ===== design/one_wire_bus_master.sv =====
// One-wire bus master top level: config registers, sequencer state, result register.
// Depends on owbm_pkg, owbm_step and one_wire_bus_master_macros.svh.
//
//  channel  | valid       | ready        | payload
//  ---------+-------------+--------------+------------------------------------------
//  input    | i_in_valid  | o_in_ready   | i_action, i_write_data, i_line_in
//  result   | o_out_valid | i_out_ready  | o_drive_low .. o_rejected (six fields)
//  config   | i_cfg_valid | o_cfg_ready  | i_cfg_index, i_cfg_data
//
// The sequencer state advances at the accepting edge and its result lands in the output register,
// so one word enters per cycle while the result side is not stalled.
// o_in_ready is high while the output register is empty or being drained.
// A stalled result holds the input side once the output register is full.
// Reset loads the default tick counts, clears the sequencer and empties the output.
`include "one_wire_bus_master_macros.svh"
module one_wire_bus_master (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_action,
    input  logic [7:0]                     i_write_data,
    input  logic                           i_line_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_drive_low,
    output logic                           o_busy_res,
    output logic                           o_done_res,
    output logic                           o_presence,
    output logic [7:0]                     o_read_byte,
    output logic                           o_rejected,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [owbm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [owbm_pkg::TICK_W-1:0]    i_cfg_data
);

    owbm_pkg::t_cfg_regs r_cfg;
    owbm_pkg::t_state    r_st;
    owbm_pkg::t_state    n_st;
    owbm_pkg::t_result   r_res;
    owbm_pkg::t_result   n_res;
    logic                r_out_valid;
    logic                in_acc;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // a zero count behaves as one tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= owbm_pkg::CFG_DEFAULTS;
        end else if (i_cfg_valid &&
                     (i_cfg_index < owbm_pkg::CFG_IDX_W'(owbm_pkg::NUM_REGS))) begin
            r_cfg[i_cfg_index[owbm_pkg::CFG_SEL_W-1:0]] <=
                (i_cfg_data == '0) ? owbm_pkg::TICK_W'(1) : i_cfg_data;
        end
    end

    owbm_step u_step (
        .i_st         (r_st),
        .i_cfg        (r_cfg),
        .i_action     (i_action),
        .i_write_data (i_write_data),
        .i_line_in    (i_line_in),
        .o_st         (n_st),
        .o_res        (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= '0;
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_st        <= n_st;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_drive_low = r_res.drive_low;
    assign o_busy_res  = r_res.busy_res;
    assign o_done_res  = r_res.done_res;
    assign o_presence  = r_res.presence;
    assign o_read_byte = r_res.read_byte;
    assign o_rejected  = r_res.rejected;

    `OWBM_ASSERT_IMP(a_done_idle, r_out_valid && r_res.done_res, !r_res.busy_res, "done while busy")
    `OWBM_ASSERT_IMP(a_rej_busy, r_out_valid && r_res.rejected, r_res.busy_res && !r_res.done_res, "reject while idle")
    `OWBM_ASSERT_IMP(a_drive_busy, r_out_valid && r_res.drive_low, r_res.busy_res, "drive low while idle")
    `OWBM_ASSERT_NEXT(a_idle_tick, in_acc && (i_action == owbm_pkg::ACT_TICK) && (r_st.phase == owbm_pkg::PH_IDLE), $stable(r_st), "idle tick moved state")
    `OWBM_ASSERT_NEXT(a_rej_hold, in_acc && (i_action != owbm_pkg::ACT_TICK) && (r_st.phase != owbm_pkg::PH_IDLE), $stable(r_st), "rejected word moved state")

endmodule

// ===== design/owbm_step.sv =====
// Next-state and result logic for one word of the one-wire bus master.
// Depends on owbm_pkg.
module owbm_step (
    input  owbm_pkg::t_state    i_st,
    input  owbm_pkg::t_cfg_regs i_cfg,
    input  logic [1:0]          i_action,
    input  logic [7:0]          i_write_data,
    input  logic                i_line_in,
    output owbm_pkg::t_state    o_st,
    output owbm_pkg::t_result   o_res
);

    logic [owbm_pkg::TICK_W-1:0] len;
    logic [owbm_pkg::TICK_W-1:0] cnt;
    logic                        done;
    logic                        rej;
    owbm_pkg::t_state            n;

    always_comb begin
        case (i_st.phase)
            owbm_pkg::PH_RST_LOW:  len = i_cfg[owbm_pkg::REG_RESET_LOW];
            owbm_pkg::PH_RST_WAIT: len = i_cfg[owbm_pkg::REG_PRESENCE_WAIT];
            owbm_pkg::PH_RST_TAIL: len = i_cfg[owbm_pkg::REG_RESET_TAIL];
            owbm_pkg::PH_SLOT_LOW: len = i_cfg[owbm_pkg::REG_SLOT_LOW];
            owbm_pkg::PH_WR_HOLD:  len = i_cfg[owbm_pkg::REG_WRITE_HOLD];
            owbm_pkg::PH_RD_WAIT:  len = i_cfg[owbm_pkg::REG_READ_SAMPLE];
            owbm_pkg::PH_RD_TAIL:  len = i_cfg[owbm_pkg::REG_READ_TAIL];
            owbm_pkg::PH_RECOVER:  len = i_cfg[owbm_pkg::REG_RECOVERY];
            default:               len = owbm_pkg::TICK_W'(1);
        endcase
    end

    // saturate the phase counter
    assign cnt = (i_st.count != '1) ? i_st.count + owbm_pkg::TICK_W'(1) : i_st.count;

    always_comb begin
        n    = i_st;
        done = 1'b0;
        rej  = 1'b0;
        if (i_action == owbm_pkg::ACT_TICK) begin
            if (i_st.phase != owbm_pkg::PH_IDLE) begin
                n.count = cnt;
                if (cnt >= len) begin
                    n.count = '0;
                    case (i_st.phase)
                        owbm_pkg::PH_RST_LOW: begin
                            n.phase = owbm_pkg::PH_RST_WAIT;
                        end
                        owbm_pkg::PH_RST_WAIT: begin
                            n.presence = ~i_line_in;
                            n.phase    = owbm_pkg::PH_RST_TAIL;
                        end
                        owbm_pkg::PH_RST_TAIL: begin
                            n.phase = owbm_pkg::PH_IDLE;
                            done    = 1'b1;
                        end
                        owbm_pkg::PH_SLOT_LOW: begin
                            n.phase = (i_st.op == owbm_pkg::ACT_WRITE) ?
                                      owbm_pkg::PH_WR_HOLD : owbm_pkg::PH_RD_WAIT;
                        end
                        owbm_pkg::PH_WR_HOLD: begin
                            n.shift = {1'b0, i_st.shift[7:1]};
                            n.phase = owbm_pkg::PH_RECOVER;
                        end
                        owbm_pkg::PH_RD_WAIT: begin
                            n.shift = {i_line_in, i_st.shift[7:1]};
                            n.phase = owbm_pkg::PH_RD_TAIL;
                        end
                        owbm_pkg::PH_RD_TAIL: begin
                            n.phase = owbm_pkg::PH_RECOVER;
                        end
                        owbm_pkg::PH_RECOVER: begin
                            if (i_st.bit_idx == owbm_pkg::LAST_BIT) begin
                                if (i_st.op == owbm_pkg::ACT_READ) begin
                                    n.read_result = i_st.shift;
                                end
                                n.bit_idx = '0;
                                n.phase   = owbm_pkg::PH_IDLE;
                                done      = 1'b1;
                            end else begin
                                n.bit_idx = i_st.bit_idx + 3'd1;
                                n.phase   = owbm_pkg::PH_SLOT_LOW;
                            end
                        end
                        default: begin
                            n.phase = owbm_pkg::PH_IDLE;
                        end
                    endcase
                end
            end
        end else if (i_st.phase != owbm_pkg::PH_IDLE) begin
            // drop the command, operation goes on untouched
            rej = 1'b1;
        end else begin
            n.op      = i_action;
            n.bit_idx = '0;
            n.count   = '0;
            if (i_action == owbm_pkg::ACT_RESET) begin
                n.phase = owbm_pkg::PH_RST_LOW;
            end else begin
                n.shift = (i_action == owbm_pkg::ACT_WRITE) ? i_write_data : 8'd0;
                n.phase = owbm_pkg::PH_SLOT_LOW;
            end
        end
    end

    assign o_st = n;

    always_comb begin
        o_res.drive_low = (n.phase == owbm_pkg::PH_RST_LOW) ||
                          (n.phase == owbm_pkg::PH_SLOT_LOW) ||
                          ((n.phase == owbm_pkg::PH_WR_HOLD) && !n.shift[0]);
        o_res.busy_res  = (n.phase != owbm_pkg::PH_IDLE);
        o_res.done_res  = done;
        o_res.presence  = n.presence;
        o_res.read_byte = n.read_result;
        o_res.rejected  = rej;
    end

endmodule

// ===== test/one_wire_bus_master_test.sv =====
// Testbench for the one-wire bus master: tick and command words in, one status word out.
// Self-checking against a sequencer model kept here; depends on owbm_pkg and the RTL.
`timescale 1ns / 1ps

module one_wire_bus_master_test;

    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 10;
    localparam int LINE_LOW      = 0;
    localparam int LINE_HIGH     = 1;
    localparam int LINE_RANDOM   = 2;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data;
        logic       line;
    } t_bus_item;

    typedef struct packed {
        logic       drive_low;
        logic       busy;
        logic       done;
        logic       presence;
        logic [7:0] read_byte;
        logic       rejected;
    } t_line_status;

    logic                           i_clk        = 1'b0;
    logic                           i_rst_n      = 1'b0;
    logic                           i_in_valid   = 1'b0;
    logic [1:0]                     i_action     = owbm_pkg::ACT_TICK;
    logic [7:0]                     i_write_data = 8'h00;
    logic                           i_line_in    = 1'b1;
    logic                           i_out_ready  = 1'b0;
    logic                           i_cfg_valid  = 1'b0;
    logic [owbm_pkg::CFG_IDX_W-1:0] i_cfg_index  = '0;
    logic [owbm_pkg::TICK_W-1:0]    i_cfg_data   = '0;
    logic                           o_in_ready;
    logic                           o_out_valid;
    logic                           o_drive_low;
    logic                           o_busy_res;
    logic                           o_done_res;
    logic                           o_presence;
    logic [7:0]                     o_read_byte;
    logic                           o_rejected;
    logic                           o_cfg_ready;

    one_wire_bus_master dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_action     (i_action),
        .i_write_data (i_write_data),
        .i_line_in    (i_line_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_drive_low  (o_drive_low),
        .o_busy_res   (o_busy_res),
        .o_done_res   (o_done_res),
        .o_presence   (o_presence),
        .o_read_byte  (o_read_byte),
        .o_rejected   (o_rejected),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // sequencer model state
    owbm_pkg::t_cfg_regs         tick_cfg = owbm_pkg::CFG_DEFAULTS;
    logic [3:0]                  seq_phase;
    logic [owbm_pkg::TICK_W-1:0] seq_count;
    logic [2:0]                  seq_bit;
    logic [7:0]                  seq_shift;
    logic                        seq_presence;
    logic [1:0]                  seq_op;
    logic [7:0]                  seq_read;

    t_bus_item    bus_items[$];
    t_line_status status_due[$];
    t_bus_item    next_item;
    t_line_status got_status;
    t_line_status want_status;
    int           items_queued   = 0;
    int           items_taken    = 0;
    int           mismatches     = 0;
    int           quiet_cycles   = 0;
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;
    int           hold_seq       = 0;
    int           hold_seen      = 0;
    int           hold_left      = 0;
    logic         item_taken     = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_line_status step_sequencer(input logic [1:0] act,
                                                    input logic [7:0] data,
                                                    input logic line);
        t_line_status                r;
        logic [owbm_pkg::TICK_W-1:0] len;
        r = '0;
        if (act == owbm_pkg::ACT_TICK) begin
            if (seq_phase != owbm_pkg::PH_IDLE) begin
                case (seq_phase)
                    owbm_pkg::PH_RST_LOW:  len = tick_cfg[owbm_pkg::REG_RESET_LOW];
                    owbm_pkg::PH_RST_WAIT: len = tick_cfg[owbm_pkg::REG_PRESENCE_WAIT];
                    owbm_pkg::PH_RST_TAIL: len = tick_cfg[owbm_pkg::REG_RESET_TAIL];
                    owbm_pkg::PH_SLOT_LOW: len = tick_cfg[owbm_pkg::REG_SLOT_LOW];
                    owbm_pkg::PH_WR_HOLD:  len = tick_cfg[owbm_pkg::REG_WRITE_HOLD];
                    owbm_pkg::PH_RD_WAIT:  len = tick_cfg[owbm_pkg::REG_READ_SAMPLE];
                    owbm_pkg::PH_RD_TAIL:  len = tick_cfg[owbm_pkg::REG_READ_TAIL];
                    owbm_pkg::PH_RECOVER:  len = tick_cfg[owbm_pkg::REG_RECOVERY];
                    default:               len = 12'd1;
                endcase
                if (seq_count != 12'hFFF)
                    seq_count = seq_count + 12'd1;
                if (seq_count >= len) begin
                    seq_count = '0;
                    case (seq_phase)
                        owbm_pkg::PH_RST_LOW: seq_phase = owbm_pkg::PH_RST_WAIT;
                        owbm_pkg::PH_RST_WAIT: begin
                            seq_presence = ~line;
                            seq_phase    = owbm_pkg::PH_RST_TAIL;
                        end
                        owbm_pkg::PH_RST_TAIL: begin
                            seq_phase = owbm_pkg::PH_IDLE;
                            r.done    = 1'b1;
                        end
                        owbm_pkg::PH_SLOT_LOW: begin
                            seq_phase = (seq_op == owbm_pkg::ACT_WRITE) ?
                                        owbm_pkg::PH_WR_HOLD : owbm_pkg::PH_RD_WAIT;
                        end
                        owbm_pkg::PH_WR_HOLD: begin
                            seq_shift = seq_shift >> 1;
                            seq_phase = owbm_pkg::PH_RECOVER;
                        end
                        owbm_pkg::PH_RD_WAIT: begin
                            seq_shift = {line, seq_shift[7:1]};
                            seq_phase = owbm_pkg::PH_RD_TAIL;
                        end
                        owbm_pkg::PH_RD_TAIL: seq_phase = owbm_pkg::PH_RECOVER;
                        owbm_pkg::PH_RECOVER: begin
                            if (seq_bit == owbm_pkg::LAST_BIT) begin
                                if (seq_op == owbm_pkg::ACT_READ)
                                    seq_read = seq_shift;
                                seq_bit   = '0;
                                seq_phase = owbm_pkg::PH_IDLE;
                                r.done    = 1'b1;
                            end else begin
                                seq_bit   = seq_bit + 3'd1;
                                seq_phase = owbm_pkg::PH_SLOT_LOW;
                            end
                        end
                        default: seq_phase = owbm_pkg::PH_IDLE;
                    endcase
                end
            end
        end else if (seq_phase != owbm_pkg::PH_IDLE) begin
            r.rejected = 1'b1;
        end else begin
            seq_op    = act;
            seq_bit   = '0;
            seq_count = '0;
            if (act == owbm_pkg::ACT_RESET) begin
                seq_phase = owbm_pkg::PH_RST_LOW;
            end else begin
                seq_shift = (act == owbm_pkg::ACT_WRITE) ? data : 8'h00;
                seq_phase = owbm_pkg::PH_SLOT_LOW;
            end
        end
        if (seq_phase == owbm_pkg::PH_RST_LOW || seq_phase == owbm_pkg::PH_SLOT_LOW)
            r.drive_low = 1'b1;
        else if (seq_phase == owbm_pkg::PH_WR_HOLD)
            r.drive_low = ~seq_shift[0];
        r.busy      = (seq_phase != owbm_pkg::PH_IDLE);
        r.presence  = seq_presence;
        r.read_byte = seq_read;
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // monitor: check results, predict accepted words, track config writes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tick_cfg     = owbm_pkg::CFG_DEFAULTS;
            seq_phase    = owbm_pkg::PH_IDLE;
            seq_count    = '0;
            seq_bit      = '0;
            seq_shift    = '0;
            seq_presence = 1'b0;
            seq_op       = owbm_pkg::ACT_TICK;
            seq_read     = '0;
            item_taken  <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got_status = '{o_drive_low, o_busy_res, o_done_res, o_presence,
                               o_read_byte, o_rejected};
                if (status_due.size() == 0) begin
                    $display("%0t: result mismatch, expected none, actual %0h",
                             $time, got_status);
                    mismatches++;
                end else begin
                    want_status = status_due.pop_front();
                    check_field("drive_low", want_status.drive_low, got_status.drive_low);
                    check_field("busy_res", want_status.busy, got_status.busy);
                    check_field("done_res", want_status.done, got_status.done);
                    check_field("presence", want_status.presence, got_status.presence);
                    check_field("read_byte", want_status.read_byte, got_status.read_byte);
                    check_field("rejected", want_status.rejected, got_status.rejected);
                end
            end
            // a word taken at the same edge as a config write still sees the old value
            if (i_in_valid && o_in_ready) begin
                status_due.push_back(step_sequencer(i_action, i_write_data, i_line_in));
                items_taken++;
            end
            if (i_cfg_valid && o_cfg_ready && i_cfg_index < owbm_pkg::NUM_REGS)
                tick_cfg[i_cfg_index[owbm_pkg::CFG_SEL_W-1:0]] =
                    (i_cfg_data == '0) ? 12'd1 : i_cfg_data;
            item_taken <= i_in_valid && o_in_ready;
            if ((o_out_valid && i_out_ready) || (i_cfg_valid && o_cfg_ready)
                    || (i_in_valid && o_in_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // driver: present the next word once the current one is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || item_taken) begin
            if (bus_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                next_item = bus_items.pop_front();
                i_in_valid   <= 1'b1;
                i_action     <= next_item.action;
                i_write_data <= next_item.data;
                i_line_in    <= next_item.line;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen   <= hold_seq;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic queue_item(input logic [1:0] act, input logic [7:0] data, input logic line);
        bus_items.push_back('{act, data, line});
        items_queued++;
    endtask

    task automatic queue_ticks(input int count, input int mode);
        logic line;
        for (int k = 0; k < count; k++) begin
            line = (mode == LINE_RANDOM) ? 1'($urandom) : (mode == LINE_HIGH);
            queue_item(owbm_pkg::ACT_TICK, 8'($urandom), line);
        end
    endtask

    function automatic int op_ticks(input logic [1:0] act);
        case (act)
            owbm_pkg::ACT_RESET:
                return int'(tick_cfg[owbm_pkg::REG_RESET_LOW])
                       + int'(tick_cfg[owbm_pkg::REG_PRESENCE_WAIT])
                       + int'(tick_cfg[owbm_pkg::REG_RESET_TAIL]);
            owbm_pkg::ACT_WRITE:
                return 8 * (int'(tick_cfg[owbm_pkg::REG_SLOT_LOW])
                            + int'(tick_cfg[owbm_pkg::REG_WRITE_HOLD])
                            + int'(tick_cfg[owbm_pkg::REG_RECOVERY]));
            owbm_pkg::ACT_READ:
                return 8 * (int'(tick_cfg[owbm_pkg::REG_SLOT_LOW])
                            + int'(tick_cfg[owbm_pkg::REG_READ_SAMPLE])
                            + int'(tick_cfg[owbm_pkg::REG_READ_TAIL])
                            + int'(tick_cfg[owbm_pkg::REG_RECOVERY]));
            default: return 0;
        endcase
    endfunction

    task automatic queue_op(input logic [1:0] act, input logic [7:0] data, input int mode);
        queue_item(act, data, 1'($urandom));
        queue_ticks(op_ticks(act), mode);
    endtask

    // mostly complete operations with random content, some stray and lone commands
    task automatic queue_random_traffic(input int amount);
        int         stop_at;
        int         span;
        int         stray_at;
        logic [1:0] act;
        stop_at = items_queued + amount;
        while (items_queued < stop_at) begin
            if ($urandom_range(99) < 80) begin
                act      = 2'($urandom_range(3, 1));
                span     = op_ticks(act);
                stray_at = ($urandom_range(99) < 30) ? int'($urandom_range(span - 1)) : -1;
                queue_item(act, 8'($urandom), 1'($urandom));
                for (int k = 0; k < span; k++) begin
                    if (k == stray_at)
                        queue_item(2'($urandom_range(3, 1)), 8'($urandom), 1'($urandom));
                    queue_item(owbm_pkg::ACT_TICK, 8'($urandom), 1'($urandom));
                end
                if ($urandom_range(1) == 1)
                    queue_ticks(int'($urandom_range(3)), LINE_RANDOM);
            end else begin
                queue_item(2'($urandom), 8'($urandom), 1'($urandom));
            end
        end
    endtask

    task automatic wait_quiet();
        while (items_taken != items_queued || status_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_register(input logic [owbm_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [owbm_pkg::TICK_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do
            @(posedge i_clk);
        while (!(i_cfg_valid && o_cfg_ready));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic randomize_timing();
        for (int r = 0; r < owbm_pkg::NUM_REGS; r++)
            write_register(owbm_pkg::CFG_IDX_W'(r),
                           owbm_pkg::TICK_W'(($urandom_range(99) < 10) ?
                                             $urandom_range(12) : $urandom_range(3)));
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // default timing: idle ticks, reset with a command dropped while busy
        queue_item(owbm_pkg::ACT_TICK, 8'h00, 1'b0);
        queue_item(owbm_pkg::ACT_TICK, 8'hFF, 1'b1);
        queue_item(owbm_pkg::ACT_RESET, 8'h00, 1'b1);
        queue_item(owbm_pkg::ACT_WRITE, 8'hA5, 1'b0);
        queue_ticks(40, LINE_RANDOM);
        wait_quiet();

        // stretch the reset pulse to its longest, then cut it below the count reached
        write_register(owbm_pkg::CFG_IDX_W'(owbm_pkg::REG_RESET_LOW), 12'hFFF);
        queue_ticks(20, LINE_RANDOM);
        wait_quiet();
        write_register(owbm_pkg::CFG_IDX_W'(owbm_pkg::REG_RESET_LOW), 12'd10);
        write_register(owbm_pkg::CFG_IDX_W'(owbm_pkg::REG_PRESENCE_WAIT), 12'd3);
        write_register(owbm_pkg::CFG_IDX_W'(owbm_pkg::REG_RESET_TAIL), 12'd4);
        queue_ticks(1 + op_ticks(owbm_pkg::ACT_RESET)
                    - int'(tick_cfg[owbm_pkg::REG_RESET_LOW]), LINE_LOW);
        queue_item(owbm_pkg::ACT_TICK, 8'h00, 1'b1);
        wait_quiet();

        // shortest timing; a zero write acts as one tick, an unknown index is ignored
        for (int r = 0; r < owbm_pkg::NUM_REGS; r++)
            write_register(owbm_pkg::CFG_IDX_W'(r),
                           (r == owbm_pkg::REG_SLOT_LOW) ? 12'd0 : 12'd1);
        write_register(4'hF, 12'hFFF);
        queue_op(owbm_pkg::ACT_WRITE, 8'h00, LINE_RANDOM);
        queue_op(owbm_pkg::ACT_WRITE, 8'hFF, LINE_RANDOM);
        queue_op(owbm_pkg::ACT_WRITE, 8'h5A, LINE_RANDOM);
        queue_op(owbm_pkg::ACT_READ, 8'h00, LINE_HIGH);
        queue_op(owbm_pkg::ACT_READ, 8'hFF, LINE_LOW);
        queue_op(owbm_pkg::ACT_RESET, 8'h00, LINE_HIGH);
        queue_item(owbm_pkg::ACT_RESET, 8'h00, 1'b0);
        queue_item(owbm_pkg::ACT_READ, 8'h3C, 1'b1);
        queue_item(owbm_pkg::ACT_RESET, 8'hC3, 1'b0);
        queue_ticks(op_ticks(owbm_pkg::ACT_RESET), LINE_LOW);
        queue_item(owbm_pkg::ACT_TICK, 8'h00, 1'b1);
        wait_quiet();

        for (int p = 0; p < 4; p++) begin
            randomize_timing();
            case (p)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 75;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 75;
                end
                default: begin
                    send_idle_pct  = 11;
                    recv_stall_pct = 11;
                end
            endcase
            if (p == 0) begin
                // hold the result side off while words keep coming
                queue_random_traffic(40);
                hold_seq++;
                queue_random_traffic(60);
            end else begin
                queue_random_traffic(100);
            end
            wait_quiet();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== one_wire_bus_master.f =====
+incdir+design
design/owbm_pkg.sv
design/owbm_step.sv
design/one_wire_bus_master.sv
test/one_wire_bus_master_test.sv
